// ===== rtl/core/cbt_pkg.sv =====
// ----------------------------------------------------------------------------
// CSV byte tokenizer package
// Shared widths, character constants, result codes and payload types.
// ----------------------------------------------------------------------------
package cbt_pkg;

  // Fixed payload widths.
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned POS_W   = 24;
  localparam int unsigned LIMIT_W = 24;

  // Reset value of the document size limit.
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'h100000;

  // Characters that steer the parser.
  localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

  // Result kinds.
  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_BYTE   = 3'd1,
    KIND_FIELD  = 3'd2,
    KIND_RECORD = 3'd3,
    KIND_ERROR  = 3'd4
  } kind_t;

  // Error codes carried with an error result.
  typedef enum logic [1:0] {
    ERR_EMPTY     = 2'd0,
    ERR_TOO_LONG  = 2'd1,
    ERR_AFTER_QT  = 2'd2,
    ERR_UNTERM_QT = 2'd3
  } err_t;

  // One input request.
  typedef struct packed {
    logic              mode;
    logic [BYTE_W-1:0] byte_in;
  } item_t;

  // One result.
  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] byte_out;
    logic [POS_W-1:0]  line;
    logic [POS_W-1:0]  column;
    err_t              error_code;
  } result_t;

endpackage

// ===== rtl/core/cbt_ifs.sv =====
// ----------------------------------------------------------------------------
// CSV byte tokenizer channel interfaces
// Valid/ready channels for input bytes, results and the limit register.
// ----------------------------------------------------------------------------

// Input byte channel.
interface cbt_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] byte_in;

  modport source (output valid, output mode, output byte_in, input ready);
  modport sink   (input valid, input mode, input byte_in, output ready);
endinterface

// Result channel.
interface cbt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  byte_out;
  logic [23:0] line;
  logic [23:0] column;
  logic [1:0]  error_code;

  modport source (output valid, output kind, output byte_out, output line,
                  output column, output error_code, input ready);
  modport sink   (input valid, input kind, input byte_out, input line,
                  input column, input error_code, output ready);
endinterface

// Configuration write channel for the document size limit.
interface cbt_cfg_if;
  logic        valid;
  logic        ready;
  logic [23:0] max_document_bytes;

  modport source (output valid, output max_document_bytes, input ready);
  modport sink   (input valid, input max_document_bytes, output ready);
endinterface

// ===== rtl/core/cbt_in_stage.sv =====
// ----------------------------------------------------------------------------
// CSV byte tokenizer input stage
// Registers one input request; refills in the cycle it is consumed.
// ----------------------------------------------------------------------------
module cbt_in_stage
  import cbt_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  take,
  output logic  vld,
  output item_t item
);

  logic  vld_r, vld_nxt;
  item_t item_r;
  logic  accept;

  // The register can load when empty or when its request leaves this cycle.
  assign in_ready = !vld_r || take;
  assign accept   = in_valid && in_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  assign vld  = vld_r;
  assign item = item_r;

endmodule

// ===== rtl/core/cbt_core.sv =====
// ----------------------------------------------------------------------------
// CSV byte tokenizer parse core
// Holds the parse state and the size limit, and computes one result per
// request from the registered request and the current state.
// ----------------------------------------------------------------------------
module cbt_core
  import cbt_pkg::*;
#(
  parameter int unsigned COUNTER_WIDTH = 24
)
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_data,
  input  logic               step,
  input  item_t              item,
  output result_t            res
);

  localparam int unsigned CW    = COUNTER_WIDTH;
  localparam int unsigned CMP_W = (CW > LIMIT_W) ? CW : LIMIT_W;

  logic [LIMIT_W-1:0] max_r;

  logic inq_r, inq_nxt;
  logic qp_r, qp_nxt;
  logic acq_r, acq_nxt;
  logic cr_r, cr_nxt;
  logic fhc_r, fhc_nxt;
  logic ro_r, ro_nxt;
  logic halted_r, halted_nxt;
  logic [CW-1:0] line_r, line_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [CW-1:0] fs_line_r, fs_line_nxt;
  logic [CW-1:0] fs_col_r, fs_col_nxt;
  logic [CW-1:0] bcnt_r, bcnt_nxt;

  logic [CW-1:0] line_inc, col_inc, bcnt_inc;
  logic [BYTE_W-1:0] b;
  logic is_comma, is_cr, is_lf, is_quote;

  // Saturating increments of the counters.
  assign line_inc = (line_r == '1) ? line_r : line_r + CW'(1);
  assign col_inc  = (col_r == '1)  ? col_r  : col_r + CW'(1);
  assign bcnt_inc = (bcnt_r == '1) ? bcnt_r : bcnt_r + CW'(1);

  assign b        = item.byte_in;
  assign is_comma = (b == CH_COMMA);
  assign is_cr    = (b == CH_CR);
  assign is_lf    = (b == CH_LF);
  assign is_quote = (b == CH_QUOTE);

  // Next state and result for the request in the input register.
  always_comb begin
    logic done;
    logic inq;
    logic acq;

    inq_nxt     = inq_r;
    qp_nxt      = qp_r;
    acq_nxt     = acq_r;
    cr_nxt      = cr_r;
    fhc_nxt     = fhc_r;
    ro_nxt      = ro_r;
    halted_nxt  = halted_r;
    line_nxt    = line_r;
    col_nxt     = col_r;
    fs_line_nxt = fs_line_r;
    fs_col_nxt  = fs_col_r;
    bcnt_nxt    = bcnt_r;
    done        = 1'b0;
    inq         = inq_r;
    acq         = acq_r;

    res.kind       = KIND_NONE;
    res.byte_out   = '0;
    res.line       = POS_W'(line_r);
    res.column     = POS_W'(col_r);
    res.error_code = ERR_EMPTY;

    if (item.mode) begin
      // End of document: report, then clear the parse state.
      priority if (halted_r) begin
        res.kind = KIND_NONE;
      end else if (bcnt_r == '0) begin
        res.kind   = KIND_ERROR;
        res.line   = POS_W'(1);
        res.column = POS_W'(1);
      end else if (inq_r && !qp_r) begin
        res.kind       = KIND_ERROR;
        res.error_code = ERR_UNTERM_QT;
      end else if (ro_r || qp_r || acq_r) begin
        res.kind   = KIND_RECORD;
        res.line   = POS_W'(fs_line_r);
        res.column = POS_W'(fs_col_r);
      end else begin
        res.kind = KIND_NONE;
      end
      inq_nxt     = 1'b0;
      qp_nxt      = 1'b0;
      acq_nxt     = 1'b0;
      cr_nxt      = 1'b0;
      fhc_nxt     = 1'b0;
      ro_nxt      = 1'b0;
      halted_nxt  = 1'b0;
      line_nxt    = CW'(1);
      col_nxt     = CW'(1);
      fs_line_nxt = CW'(1);
      fs_col_nxt  = CW'(1);
      bcnt_nxt    = '0;
    end else if (!halted_r) begin
      bcnt_nxt = bcnt_inc;
      if (CMP_W'(bcnt_inc) > CMP_W'(max_r)) begin
        // Document grew past the limit.
        halted_nxt     = 1'b1;
        res.kind       = KIND_ERROR;
        res.line       = POS_W'(1);
        res.column     = POS_W'(1);
        res.error_code = ERR_TOO_LONG;
      end else begin
        // The LF of a CRLF pair is swallowed.
        if (cr_r) begin
          cr_nxt = 1'b0;
          if (is_lf) begin
            done = 1'b1;
          end
        end

        // A quote inside quotes waits for the next byte: a second quote is
        // an escaped quote, anything else closes the field.
        if (!done && qp_r) begin
          qp_nxt = 1'b0;
          if (is_quote) begin
            res.kind     = KIND_BYTE;
            res.byte_out = b;
            col_nxt      = col_inc;
            done         = 1'b1;
          end else begin
            inq = 1'b0;
            acq = 1'b1;
          end
        end

        // Inside a quoted field every byte but a quote is content.
        if (!done && inq) begin
          if (is_quote) begin
            qp_nxt  = 1'b1;
            col_nxt = col_inc;
          end else begin
            res.kind     = KIND_BYTE;
            res.byte_out = b;
            if (is_cr || is_lf) begin
              line_nxt = line_inc;
              col_nxt  = CW'(1);
              cr_nxt   = is_cr;
            end else begin
              col_nxt = col_inc;
            end
          end
          done = 1'b1;
        end

        // Outside quotes.
        if (!done) begin
          priority if (acq && !(is_comma || is_cr || is_lf)) begin
            halted_nxt     = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_AFTER_QT;
          end else if (!acq && is_quote && !fhc_r) begin
            inq     = 1'b1;
            ro_nxt  = 1'b1;
            col_nxt = col_inc;
          end else if (is_comma) begin
            res.kind    = KIND_FIELD;
            res.line    = POS_W'(fs_line_r);
            res.column  = POS_W'(fs_col_r);
            col_nxt     = col_inc;
            fs_line_nxt = line_r;
            fs_col_nxt  = col_inc;
            fhc_nxt     = 1'b0;
            ro_nxt      = 1'b1;
          end else if (is_cr || is_lf) begin
            res.kind    = KIND_RECORD;
            res.line    = POS_W'(fs_line_r);
            res.column  = POS_W'(fs_col_r);
            line_nxt    = line_inc;
            col_nxt     = CW'(1);
            cr_nxt      = is_cr;
            fs_line_nxt = line_inc;
            fs_col_nxt  = CW'(1);
            fhc_nxt     = 1'b0;
            ro_nxt      = 1'b0;
          end else begin
            res.kind     = KIND_BYTE;
            res.byte_out = b;
            fhc_nxt      = 1'b1;
            ro_nxt       = 1'b1;
            col_nxt      = col_inc;
          end
          acq = 1'b0;
        end

        inq_nxt = inq;
        acq_nxt = acq;
      end
    end
  end

  // Size limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      max_r <= cfg_data;
    end
  end

  // Parse state advances once per request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_r     <= 1'b0;
      qp_r      <= 1'b0;
      acq_r     <= 1'b0;
      cr_r      <= 1'b0;
      fhc_r     <= 1'b0;
      ro_r      <= 1'b0;
      halted_r  <= 1'b0;
      line_r    <= CW'(1);
      col_r     <= CW'(1);
      fs_line_r <= CW'(1);
      fs_col_r  <= CW'(1);
      bcnt_r    <= '0;
    end else if (step) begin
      inq_r     <= inq_nxt;
      qp_r      <= qp_nxt;
      acq_r     <= acq_nxt;
      cr_r      <= cr_nxt;
      fhc_r     <= fhc_nxt;
      ro_r      <= ro_nxt;
      halted_r  <= halted_nxt;
      line_r    <= line_nxt;
      col_r     <= col_nxt;
      fs_line_r <= fs_line_nxt;
      fs_col_r  <= fs_col_nxt;
      bcnt_r    <= bcnt_nxt;
    end
  end

endmodule

// ===== rtl/core/cbt_out_stage.sv =====
// ----------------------------------------------------------------------------
// CSV byte tokenizer output stage
// Result register that holds a result until the sink takes it.
// ----------------------------------------------------------------------------
module cbt_out_stage
  import cbt_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res_in,
  output logic    space,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t res
);

  logic    vld_r, vld_nxt;
  result_t res_r;

  // Room for a new result when empty or when the held one leaves now.
  assign space = !vld_r || out_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = vld_r;
  assign res       = res_r;

endmodule

// ===== rtl/core/csv_byte_tokenizer.sv =====
// ----------------------------------------------------------------------------
// CSV byte tokenizer
// Streaming CSV tokenizer: one document byte or end marker in, one result out.
// Path: the request is registered in the input stage, its result in the result register.
// Throughput: one request per cycle; a stalled result sink stalls the input.
// The rate is set by the single parse state update per request.
// Reset: synchronous active-low; clears parse state, limit returns to 1048576.
// ----------------------------------------------------------------------------
module csv_byte_tokenizer
  import cbt_pkg::*;
#(
  parameter int unsigned COUNTER_WIDTH = 24
)
(
  input  logic             clk,
  input  logic             rst_n,
  cbt_in_if.sink           in_chan,
  cbt_out_if.source        out_chan,
  cbt_cfg_if.sink          cfg_chan
);

  item_t   in_item;
  item_t   item;
  logic    item_vld;
  logic    space;
  logic    step;
  result_t res_calc;
  result_t res_out;

  assign in_item.mode    = in_chan.mode;
  assign in_item.byte_in = in_chan.byte_in;

  // A request moves into the result register whenever there is room.
  assign step = item_vld && space;

  // The limit register takes a write every cycle.
  assign cfg_chan.ready = 1'b1;

  cbt_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .in_item  (in_item),
    .take     (step),
    .vld      (item_vld),
    .item     (item)
  );

  cbt_core #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_chan.valid),
    .cfg_data (cfg_chan.max_document_bytes),
    .step     (step),
    .item     (item),
    .res      (res_calc)
  );

  cbt_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .res_in    (res_calc),
    .space     (space),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .res       (res_out)
  );

  assign out_chan.kind       = res_out.kind;
  assign out_chan.byte_out   = res_out.byte_out;
  assign out_chan.line       = res_out.line;
  assign out_chan.column     = res_out.column;
  assign out_chan.error_code = res_out.error_code;

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// CSV byte tokenizer testbench
// Sends directed and random CSV documents through the tokenizer, one byte or
// end marker per request, and checks every result against a cycle-free
// prediction of the parse. Both channel ends idle at random, the size limit
// register is changed between phases, and one phase holds the result channel
// off long enough for the tokenizer to stall its input.
// ----------------------------------------------------------------------------
module testbench;
  import cbt_pkg::*;

  localparam logic [POS_W-1:0] POS_MAX     = {POS_W{1'b1}};
  localparam logic [POS_W-1:0] POS_ONE     = POS_W'(1);
  localparam logic [BYTE_W-1:0] CH_LETTER_A = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LETTER_X = 8'h78;
  localparam int               HOLD_LEN    = 200;

  logic clk;
  logic rst_n;

  cbt_in_if  in_if();
  cbt_out_if out_if();
  cbt_cfg_if cfg_if();

  csv_byte_tokenizer u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  // Clock generation.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Idle rates in percent and the long result hold-off.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int          hold_cycles = 0;
  logic        hold_req    = 1'b0;
  logic        hold_seen   = 1'b0;
  int          live_items;
  int          fail_count  = 0;

  // Expected results in order of their requests.
  result_t expected_tokens[$];

  // Document under construction.
  logic [BYTE_W-1:0] doc_bytes[$];

  // Parser state as the tokenizer should hold it.
  logic [LIMIT_W-1:0] doc_limit;
  logic               in_quotes, quote_seen, after_close, cr_seen;
  logic               field_has_text, record_open, doc_halted;
  logic [POS_W-1:0]   line_cnt, col_cnt, field_line, field_col, byte_cnt;

  function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
    return (v == POS_MAX) ? v : v + POS_ONE;
  endfunction

  function automatic result_t make_token(input kind_t k, input logic [BYTE_W-1:0] b,
                                         input logic [POS_W-1:0] ln,
                                         input logic [POS_W-1:0] cl, input err_t e);
    result_t t;
    t.kind       = k;
    t.byte_out   = b;
    t.line       = ln;
    t.column     = cl;
    t.error_code = e;
    return t;
  endfunction

  function automatic void clear_document();
    in_quotes      = 1'b0;
    quote_seen     = 1'b0;
    after_close    = 1'b0;
    cr_seen        = 1'b0;
    field_has_text = 1'b0;
    record_open    = 1'b0;
    doc_halted     = 1'b0;
    line_cnt       = POS_ONE;
    col_cnt        = POS_ONE;
    field_line     = POS_ONE;
    field_col      = POS_ONE;
    byte_cnt       = '0;
  endfunction

  function automatic void start_line(input logic is_cr);
    line_cnt = sat_inc(line_cnt);
    col_cnt  = POS_ONE;
    cr_seen  = is_cr;
  endfunction

  function automatic void start_field();
    field_line     = line_cnt;
    field_col      = col_cnt;
    field_has_text = 1'b0;
  endfunction

  // A comma or line end outside quotes closes the current field.
  function automatic bit close_field(input logic [BYTE_W-1:0] c, output result_t t);
    t = make_token(KIND_NONE, '0, line_cnt, col_cnt, ERR_EMPTY);
    if (c == CH_COMMA) begin
      t = make_token(KIND_FIELD, '0, field_line, field_col, ERR_EMPTY);
      col_cnt = sat_inc(col_cnt);
      start_field();
      record_open = 1'b1;
      return 1'b1;
    end
    if (c == CH_CR || c == CH_LF) begin
      t = make_token(KIND_RECORD, '0, field_line, field_col, ERR_EMPTY);
      start_line(c == CH_CR);
      start_field();
      record_open = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Token caused by one document byte.
  function automatic result_t token_for_byte(input logic [BYTE_W-1:0] c);
    logic [POS_W-1:0] ln;
    logic [POS_W-1:0] cl;
    result_t          t;
    ln = line_cnt;
    cl = col_cnt;
    if (doc_halted) return make_token(KIND_NONE, '0, ln, cl, ERR_EMPTY);
    byte_cnt = sat_inc(byte_cnt);
    if (byte_cnt > doc_limit) begin
      doc_halted = 1'b1;
      return make_token(KIND_ERROR, '0, POS_ONE, POS_ONE, ERR_TOO_LONG);
    end
    // The LF of a CRLF pair is swallowed.
    if (cr_seen) begin
      cr_seen = 1'b0;
      if (c == CH_LF) return make_token(KIND_NONE, '0, ln, cl, ERR_EMPTY);
    end
    // A quote inside quotes is either doubled or closes the field.
    if (quote_seen) begin
      quote_seen = 1'b0;
      if (c == CH_QUOTE) begin
        col_cnt = sat_inc(col_cnt);
        return make_token(KIND_BYTE, c, ln, cl, ERR_EMPTY);
      end
      in_quotes   = 1'b0;
      after_close = 1'b1;
    end
    if (in_quotes) begin
      if (c == CH_QUOTE) begin
        quote_seen = 1'b1;
        col_cnt    = sat_inc(col_cnt);
        return make_token(KIND_NONE, '0, ln, cl, ERR_EMPTY);
      end
      if (c == CH_CR || c == CH_LF) start_line(c == CH_CR);
      else col_cnt = sat_inc(col_cnt);
      return make_token(KIND_BYTE, c, ln, cl, ERR_EMPTY);
    end
    // Only a delimiter may follow a closing quote.
    if (after_close) begin
      after_close = 1'b0;
      if (close_field(c, t)) return t;
      doc_halted = 1'b1;
      return make_token(KIND_ERROR, '0, ln, cl, ERR_AFTER_QT);
    end
    if (c == CH_QUOTE && !field_has_text) begin
      in_quotes   = 1'b1;
      record_open = 1'b1;
      col_cnt     = sat_inc(col_cnt);
      return make_token(KIND_NONE, '0, ln, cl, ERR_EMPTY);
    end
    if (close_field(c, t)) return t;
    field_has_text = 1'b1;
    record_open    = 1'b1;
    col_cnt        = sat_inc(col_cnt);
    return make_token(KIND_BYTE, c, ln, cl, ERR_EMPTY);
  endfunction

  // Token caused by the end marker; the parse state is cleared afterwards.
  function automatic result_t token_for_end();
    result_t t;
    if (doc_halted)
      t = make_token(KIND_NONE, '0, line_cnt, col_cnt, ERR_EMPTY);
    else if (byte_cnt == '0)
      t = make_token(KIND_ERROR, '0, POS_ONE, POS_ONE, ERR_EMPTY);
    else if (in_quotes && !quote_seen)
      t = make_token(KIND_ERROR, '0, line_cnt, col_cnt, ERR_UNTERM_QT);
    else if (record_open || quote_seen || after_close)
      t = make_token(KIND_RECORD, '0, field_line, field_col, ERR_EMPTY);
    else
      t = make_token(KIND_NONE, '0, line_cnt, col_cnt, ERR_EMPTY);
    clear_document();
    return t;
  endfunction

  // Append one byte to the document under construction.
  function automatic void add_byte(input logic [BYTE_W-1:0] c);
    doc_bytes.insert(doc_bytes.size(), c);
  endfunction

  // Send one request and record its expected token once it is accepted.
  task automatic send_item(input logic mode, input logic [BYTE_W-1:0] b);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.mode    <= mode;
    in_if.byte_in <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    live_items++;
    if (mode) expected_tokens.insert(expected_tokens.size(), token_for_end());
    else expected_tokens.insert(expected_tokens.size(), token_for_byte(b));
  endtask

  // Send the built document followed by its end marker.
  task automatic send_document();
    foreach (doc_bytes[i]) send_item(1'b0, doc_bytes[i]);
    send_item(1'b1, BYTE_W'($urandom_range(255)));
  endtask

  // Drop the input request and wait until every token has come back.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    wait_idle();
    cfg_if.valid              <= 1'b1;
    cfg_if.max_document_bytes <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    doc_limit = value;
    cfg_if.valid <= 1'b0;
  endtask

  // Byte that carries no meaning to the parser.
  function automatic logic [BYTE_W-1:0] plain_byte();
    logic [BYTE_W-1:0] c;
    if ($urandom_range(1) == 0) return BYTE_W'(CH_LETTER_A + $urandom_range(25));
    do c = BYTE_W'($urandom_range(255));
    while (c == CH_QUOTE || c == CH_COMMA || c == CH_CR || c == CH_LF);
    return c;
  endfunction

  // Byte drawn mostly from the characters that steer the parser.
  function automatic logic [BYTE_W-1:0] noise_byte();
    case ($urandom_range(5))
      0: return CH_QUOTE;
      1: return CH_COMMA;
      2: return CH_CR;
      3: return CH_LF;
      4: return CH_LETTER_A;
      default: return BYTE_W'($urandom_range(255));
    endcase
  endfunction

  function automatic void push_plain_field();
    repeat ($urandom_range(4)) add_byte(plain_byte());
  endfunction

  // Quoted field with doubled quotes, embedded line ends and commas.
  function automatic void push_quoted_field();
    logic [BYTE_W-1:0] c;
    add_byte(CH_QUOTE);
    repeat ($urandom_range(5)) begin
      case ($urandom_range(9))
        0: begin
          add_byte(CH_QUOTE);
          add_byte(CH_QUOTE);
        end
        1: add_byte(CH_CR);
        2: add_byte(CH_LF);
        3: begin
          add_byte(CH_CR);
          add_byte(CH_LF);
        end
        4: add_byte(CH_COMMA);
        default: begin
          do c = BYTE_W'($urandom_range(255));
          while (c == CH_QUOTE);
          add_byte(c);
        end
      endcase
    end
    add_byte(CH_QUOTE);
  endfunction

  function automatic void push_line_end();
    case ($urandom_range(2))
      0: add_byte(CH_CR);
      1: add_byte(CH_LF);
      default: begin
        add_byte(CH_CR);
        add_byte(CH_LF);
      end
    endcase
  endfunction

  // Well-formed document of a few records with random content.
  function automatic void build_good_document();
    int unsigned records;
    int unsigned fields;
    doc_bytes.delete();
    records = $urandom_range(1, 3);
    for (int r = 0; r < records; r++) begin
      fields = $urandom_range(1, 4);
      for (int f = 0; f < fields; f++) begin
        if (f != 0) add_byte(CH_COMMA);
        if ($urandom_range(1) == 0) push_plain_field();
        else push_quoted_field();
      end
      if (r != records - 1 || $urandom_range(1) == 0) push_line_end();
    end
  endfunction

  // Mostly well-formed documents; the rest are broken or pure noise.
  function automatic void build_random_document();
    int unsigned drop;
    build_good_document();
    case ($urandom_range(9))
      0: begin
        doc_bytes.delete();
        repeat ($urandom_range(10)) add_byte(noise_byte());
      end
      1: begin
        drop = $urandom_range(1, 3);
        while (drop != 0 && doc_bytes.size() != 0) begin
          void'(doc_bytes.pop_back());
          drop--;
        end
      end
      2: begin
        doc_bytes.delete();
        push_quoted_field();
        add_byte(plain_byte());
        push_plain_field();
      end
      3: doc_bytes.insert($urandom_range(doc_bytes.size()), noise_byte());
      default: ;
    endcase
  endfunction

  // Result channel: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen   = hold_req;
      hold_cycles = HOLD_LEN;
    end
    if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each accepted result with the oldest expected token.
  always @(posedge clk) begin : check_tokens
    result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_tokens.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: kind %0d byte %02h line %0d col %0d err %0d",
                   out_if.kind, out_if.byte_out, out_if.line, out_if.column,
                   out_if.error_code);
      end else begin
        want = expected_tokens.pop_front();
        if (out_if.kind !== want.kind || out_if.byte_out !== want.byte_out ||
            out_if.line !== want.line || out_if.column !== want.column ||
            out_if.error_code !== want.error_code) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected kind %0d byte %02h line %0d col %0d err %0d,",
                     want.kind, want.byte_out, want.line, want.column,
                     want.error_code,
                     " got kind %0d byte %02h line %0d col %0d err %0d",
                     out_if.kind, out_if.byte_out, out_if.line, out_if.column,
                     out_if.error_code);
        end
      end
    end
  end

  // Empty document, line ends, quoting rules, byte extremes and errors.
  task automatic test_directed_cases();
    doc_bytes.delete();
    send_document();
    doc_bytes = {8'h00, CH_COMMA, 8'hFF, CH_CR, CH_LF, CH_QUOTE, CH_LETTER_X, CH_QUOTE,
                 CH_QUOTE, CH_CR, CH_LF, CH_QUOTE, CH_COMMA};
    send_document();
    // Text after a closing quote halts until the end marker.
    doc_bytes = {CH_QUOTE, CH_LETTER_A, CH_QUOTE, CH_LETTER_X, CH_LETTER_A};
    send_document();
    // Unterminated quote at the end marker.
    doc_bytes = {CH_QUOTE, CH_LETTER_X, CH_LF};
    send_document();
    // A quote inside an unquoted field is plain content.
    doc_bytes = {CH_LETTER_A, CH_QUOTE, CH_LF};
    send_document();
    // Empty quoted field closed by the end marker.
    doc_bytes = {CH_QUOTE, CH_QUOTE};
    send_document();
  endtask

  // Size limit at its extremes, zero included.
  task automatic test_size_limit();
    write_limit(24'd1);
    doc_bytes = {CH_LETTER_A, CH_LETTER_X};
    send_document();
    write_limit('0);
    doc_bytes = {CH_LETTER_A};
    send_document();
    write_limit(POS_MAX);
    doc_bytes = {CH_LETTER_A, CH_COMMA, CH_LETTER_X};
    send_document();
  endtask

  task automatic test_random_documents(input logic [LIMIT_W-1:0] limit,
                                       input int target);
    int start;
    write_limit(limit);
    start = live_items;
    while (live_items - start < target) begin
      build_random_document();
      send_document();
    end
  endtask

  // Hold the result channel off while requests keep coming.
  task automatic test_output_stall();
    wait_idle();
    hold_req = ~hold_req;
    repeat (4) begin
      build_good_document();
      send_document();
    end
  endtask

  initial begin
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    live_items     = 0;
    doc_limit      = LIMIT_RESET;
    clear_document();
    rst_n                     <= 1'b0;
    in_if.valid               <= 1'b0;
    in_if.mode                <= 1'b0;
    in_if.byte_in             <= '0;
    cfg_if.valid              <= 1'b0;
    cfg_if.max_document_bytes <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 7;
    recv_idle_pct = 66;
    test_directed_cases();
    test_size_limit();
    test_random_documents(POS_MAX, 500);

    send_idle_pct = 66;
    recv_idle_pct = 7;
    test_random_documents(LIMIT_W'($urandom_range(6, 60)), 500);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_documents(LIMIT_RESET, 500);
    test_output_stall();

    wait_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Run limit far beyond the slowest correct run.
  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

endmodule
